// ===== src/aspect_fit_fill_transform_top_defines.svh =====
// ----------------------------------------------------------------------------
// Aspect fit/fill transform: assertion macros
// Shared checks used by the top level of the transform block.
// ----------------------------------------------------------------------------
`ifndef ASPECT_FIT_FILL_TRANSFORM_TOP_DEFINES_SVH
`define ASPECT_FIT_FILL_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define AFFIT_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("affit check failed");

// Next-cycle implication, disabled while reset is low
`define AFFIT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("affit check failed");

`endif

// ===== src/affit_pkg.sv =====
// ----------------------------------------------------------------------------
// affit_pkg
// Types, codes and sizes shared by the aspect fit/fill transform modules.
// ----------------------------------------------------------------------------
package affit_pkg;

    // Default sizing
    localparam int DIM_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 32;
    localparam int TOL_W      = 16;
    localparam int MODE_W     = 2;
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TOL_SHIFT  = 16;
    localparam int QUEUE_DEPTH = 4;

    // Mode register codes; any other code means stretch
    localparam logic [MODE_W-1:0] MODE_FILL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIT  = 2'd1;

    // Outcome codes
    localparam logic [CODE_W-1:0] OC_INVALID = 2'd0;
    localparam logic [CODE_W-1:0] OC_IDENT   = 2'd1;
    localparam logic [CODE_W-1:0] OC_APPLIED = 2'd2;
    localparam logic [CODE_W-1:0] OC_SAT     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 1'd1;

    // Register reset values
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_FILL;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd328;

    // Classification handed from the front end to the divider
    typedef struct packed {
        logic              ident;   // return the identity transform
        logic [CODE_W-1:0] code;    // outcome for an identity request
        logic              axis_x;  // scaled axis is x, else y
        logic              sat;     // quotient does not fit the scale field
    } t_ctl;

endpackage

// ===== src/affit_front.sv =====
// ----------------------------------------------------------------------------
// affit_front
// Accepts dimension requests, forms the cross products and classifies each
// request as identity or divide, picking numerator, denominator and axis.
// ----------------------------------------------------------------------------
module affit_front #(
    parameter int DIM_BITS  = affit_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = affit_pkg::FRAC_BITS_DEF,
    localparam int DW = (DIM_BITS < affit_pkg::IN_W) ? DIM_BITS : affit_pkg::IN_W,
    localparam int PW = 2 * DW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [affit_pkg::MODE_W-1:0]    i_mode,
    input  logic [affit_pkg::TOL_W-1:0]     i_tol,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [affit_pkg::IN_W-1:0]      i_cw,
    input  logic [affit_pkg::IN_W-1:0]      i_ch,
    input  logic [affit_pkg::IN_W-1:0]      i_tw,
    input  logic [affit_pkg::IN_W-1:0]      i_th,
    output logic                            o_valid,
    input  logic                            i_ready,
    output affit_pkg::t_ctl                 o_ctl,
    output logic [PW-1:0]                   o_num,
    output logic [PW-1:0]                   o_den
);

    localparam int CW        = PW + affit_pkg::TOL_SHIFT;
    localparam int SW        = PW + affit_pkg::OUT_W;
    localparam int SAT_SHIFT = affit_pkg::OUT_W - FRAC_BITS;

    logic w_en;

    // Stage 1: products
    logic [DW-1:0] w_cw, w_ch, w_tw, w_th;
    logic [PW-1:0] w_p1, w_p2;
    logic          w_zero;
    logic          r_v1;
    logic          r_zero1;
    logic [PW-1:0] r_p1_1, r_p2_1;

    // Stage 2: deviation and tolerance product
    logic          r_v2;
    logic          r_zero2;
    logic          r_wider2;
    logic [PW-1:0] r_p1_2, r_p2_2, r_dev2;
    logic [CW-1:0] r_tolp2;

    // Stage 3: classification
    logic            w_near, w_stretch, w_axis_x, w_sat;
    logic [PW-1:0]   w_num, w_den;
    affit_pkg::t_ctl w_ctl;
    logic            r_v3;
    affit_pkg::t_ctl r_ctl;
    logic [PW-1:0]   r_num, r_den;

    // Advance the whole front end unless the last stage is blocked
    assign w_en    = !(r_v3 && !i_ready);
    assign o_ready = w_en;

    assign w_cw   = i_cw[DW-1:0];
    assign w_ch   = i_ch[DW-1:0];
    assign w_tw   = i_tw[DW-1:0];
    assign w_th   = i_th[DW-1:0];
    assign w_p1   = PW'(w_cw) * PW'(w_th);
    assign w_p2   = PW'(w_ch) * PW'(w_tw);
    assign w_zero = (w_cw == '0) || (w_ch == '0) || (w_tw == '0) || (w_th == '0);

    // Classify against tolerance and mode
    always_comb begin
        w_near    = (CW'(r_dev2) << affit_pkg::TOL_SHIFT) <= r_tolp2;
        w_stretch = (i_mode != affit_pkg::MODE_FILL) && (i_mode != affit_pkg::MODE_FIT);
        w_axis_x  = (i_mode == affit_pkg::MODE_FILL) == r_wider2;
        w_num     = w_axis_x ? r_p2_2 : r_p1_2;
        w_den     = w_axis_x ? r_p1_2 : r_p2_2;
        w_sat     = SW'(w_num) >= (SW'(w_den) << SAT_SHIFT);
        w_ctl.ident  = r_zero2 || w_stretch || w_near;
        w_ctl.code   = r_zero2 ? affit_pkg::OC_INVALID : affit_pkg::OC_IDENT;
        w_ctl.axis_x = w_axis_x;
        w_ctl.sat    = w_sat;
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero1  <= w_zero;
            r_p1_1   <= w_p1;
            r_p2_1   <= w_p2;
            r_zero2  <= r_zero1;
            r_wider2 <= r_p1_1 > r_p2_1;
            r_p1_2   <= r_p1_1;
            r_p2_2   <= r_p2_1;
            r_dev2   <= (r_p1_1 > r_p2_1) ? (r_p1_1 - r_p2_1) : (r_p2_1 - r_p1_1);
            r_tolp2  <= CW'(i_tol) * CW'(r_p2_1);
            r_ctl    <= w_ctl;
            r_num    <= w_num;
            r_den    <= w_den;
        end
    end

    assign o_valid = r_v3;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

// ===== src/affit_queue.sv =====
// ----------------------------------------------------------------------------
// affit_queue
// Short first-in first-out buffer that decouples the front end from the
// divider pipeline. Entries sit in a small storage array and the head of the
// queue is presented from an output register.
// ----------------------------------------------------------------------------
module affit_queue #(
    parameter int W     = 8,
    parameter int DEPTH = affit_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          r_head_v;
    logic [W-1:0]  r_head;
    logic          w_push, w_pop, w_load, w_mem_rd, w_mem_wr;

    assign o_ready  = r_count != NW'(DEPTH);
    assign o_valid  = r_head_v;
    assign o_data   = r_head;
    assign w_push   = i_valid && o_ready;
    assign w_pop    = r_head_v && i_ready;
    // Head register is free this cycle
    assign w_load   = !r_head_v || w_pop;
    // Refill the head from storage, or pass a request straight through when empty
    assign w_mem_rd = w_load && (r_count != '0);
    assign w_mem_wr = w_push && !(w_load && (r_count == '0));

    // Track pointers, fill level and head valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_head_v <= 1'b0;
        end else begin
            if (w_mem_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_mem_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_mem_wr && !w_mem_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_mem_rd && !w_mem_wr) begin
                r_count <= r_count - 1'b1;
            end
            if (w_load) begin
                r_head_v <= w_mem_rd || w_push;
            end
        end
    end

    // Store entries and load the head
    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (w_mem_rd) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (w_load && w_push) begin
            r_head <= i_data;
        end
    end

endmodule

// ===== src/affit_back.sv =====
// ----------------------------------------------------------------------------
// affit_back
// Pipelined restoring divider, one quotient bit per stage, followed by the
// offset computation and the result register.
// ----------------------------------------------------------------------------
module affit_back #(
    parameter int DIM_BITS  = affit_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = affit_pkg::FRAC_BITS_DEF,
    localparam int DW = (DIM_BITS < affit_pkg::IN_W) ? DIM_BITS : affit_pkg::IN_W,
    localparam int PW = 2 * DW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  affit_pkg::t_ctl                     i_ctl,
    input  logic [PW-1:0]                       i_num,
    input  logic [PW-1:0]                       i_den,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [affit_pkg::OUT_W-1:0]         o_scale_x,
    output logic [affit_pkg::OUT_W-1:0]         o_scale_y,
    output logic signed [affit_pkg::OUT_W-1:0]  o_offset_x,
    output logic signed [affit_pkg::OUT_W-1:0]  o_offset_y,
    output logic [affit_pkg::CODE_W-1:0]        o_outcome
);

    localparam int QW = affit_pkg::OUT_W;
    localparam int NW = PW + FRAC_BITS + QW;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic w_en;
    logic [NW-1:0] w_n_ext;

    // Divider stage registers; index k holds the state after k quotient bits
    logic            r_v   [0:QW];
    affit_pkg::t_ctl r_ctl [0:QW];
    logic [PW-1:0]   r_den [0:QW];
    logic [PW-1:0]   r_rem [0:QW];
    logic [QW-1:0]   r_low [0:QW];
    logic [QW-1:0]   r_q   [0:QW];

    // Result stage
    logic [QW-1:0]        w_scale;
    logic signed [QW+1:0] w_diff, w_half;
    logic [QW-1:0]        w_off;
    logic                 r_ov;
    logic [QW-1:0]        r_sx, r_sy, r_ox, r_oy;
    logic [affit_pkg::CODE_W-1:0] r_oc;

    // Advance the pipeline unless the result is held
    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    // Dividend is num scaled by the fraction; its top part seeds the remainder
    assign w_n_ext = NW'(i_num) << FRAC_BITS;

    // Shift stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= QW; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[QW];
        end
    end

    // Load the first stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl[0] <= i_ctl;
            r_den[0] <= i_den;
            r_rem[0] <= PW'(w_n_ext >> QW);
            r_low[0] <= w_n_ext[QW-1:0];
            r_q[0]   <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [PW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_rem[k], r_low[k][QW-1]};
        assign w_ge = w_t >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ctl[k+1] <= r_ctl[k];
                r_den[k+1] <= r_den[k];
                r_rem[k+1] <= w_ge ? PW'(w_t - {1'b0, r_den[k]}) : PW'(w_t);
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
            end
        end
    end

    // Saturate the scale and derive floor((1 - scale) / 2)
    always_comb begin
        w_scale = r_ctl[QW].sat ? '1 : r_q[QW];
        w_diff  = $signed({2'b00, ONE_Q}) - $signed({2'b00, w_scale});
        w_half  = w_diff >>> 1;
        w_off   = w_half[QW-1:0];
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_ctl[QW].ident) begin
                r_sx <= ONE_Q;
                r_sy <= ONE_Q;
                r_ox <= '0;
                r_oy <= '0;
                r_oc <= r_ctl[QW].code;
            end else begin
                r_sx <= r_ctl[QW].axis_x ? w_scale : ONE_Q;
                r_sy <= r_ctl[QW].axis_x ? ONE_Q : w_scale;
                r_ox <= r_ctl[QW].axis_x ? w_off : '0;
                r_oy <= r_ctl[QW].axis_x ? '0 : w_off;
                r_oc <= r_ctl[QW].sat ? affit_pkg::OC_SAT : affit_pkg::OC_APPLIED;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_scale_x  = r_sx;
    assign o_scale_y  = r_sy;
    assign o_offset_x = $signed(r_ox);
    assign o_offset_y = $signed(r_oy);
    assign o_outcome  = r_oc;

endmodule

// ===== src/aspect_fit_fill_transform_top.sv =====
// ----------------------------------------------------------------------------
// aspect_fit_fill_transform_top
// Turns content and target sizes into a Q16.16 scale/offset sampling transform.
// ----------------------------------------------------------------------------
// One request per cycle is accepted and one result per cycle is delivered in
// steady state while nothing stalls. A request passes, in order, through three
// front-end stages (products, tolerance product, classification), one queue
// slot, the divider load stage, 32 restoring divider stages that each produce
// one quotient bit, and the result register. The queue (four stored entries
// plus its output register) lets the front end keep accepting while the
// result side is stalled.
`include "aspect_fit_fill_transform_top_defines.svh"

module aspect_fit_fill_transform_top #(
    parameter int DIM_BITS  = affit_pkg::DIM_BITS_DEF,
    parameter int FRAC_BITS = affit_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [affit_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [affit_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [affit_pkg::IN_W-1:0]           i_content_width,
    input  logic [affit_pkg::IN_W-1:0]           i_content_height,
    input  logic [affit_pkg::IN_W-1:0]           i_target_width,
    input  logic [affit_pkg::IN_W-1:0]           i_target_height,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [affit_pkg::OUT_W-1:0]          o_scale_x,
    output logic [affit_pkg::OUT_W-1:0]          o_scale_y,
    output logic signed [affit_pkg::OUT_W-1:0]   o_offset_x,
    output logic signed [affit_pkg::OUT_W-1:0]   o_offset_y,
    output logic [affit_pkg::CODE_W-1:0]         o_outcome
);

    localparam int DW = (DIM_BITS < affit_pkg::IN_W) ? DIM_BITS : affit_pkg::IN_W;
    localparam int PW = 2 * DW;
    localparam int CTL_W = $bits(affit_pkg::t_ctl);
    localparam int QD_W = CTL_W + 2 * PW;

    logic [affit_pkg::MODE_W-1:0] r_mode;
    logic [affit_pkg::TOL_W-1:0]  r_tol;

    logic            w_f_valid, w_q_ready, w_q_valid, w_b_ready;
    affit_pkg::t_ctl w_f_ctl, w_b_ctl;
    logic [PW-1:0]   w_f_num, w_f_den, w_b_num, w_b_den;
    logic [QD_W-1:0] w_q_in, w_q_out;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= affit_pkg::MODE_RESET;
            r_tol  <= affit_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                affit_pkg::REG_FIT_MODE: r_mode <= i_cfg_data[affit_pkg::MODE_W-1:0];
                affit_pkg::REG_TOL:      r_tol  <= i_cfg_data[affit_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: products and classification
    affit_front #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_tol   (r_tol),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cw    (i_content_width),
        .i_ch    (i_content_height),
        .i_tw    (i_target_width),
        .i_th    (i_target_height),
        .o_valid (w_f_valid),
        .i_ready (w_q_ready),
        .o_ctl   (w_f_ctl),
        .o_num   (w_f_num),
        .o_den   (w_f_den)
    );

    // Queue between the front end and the divider
    assign w_q_in = {w_f_ctl, w_f_num, w_f_den};
    assign {w_b_ctl, w_b_num, w_b_den} = w_q_out;

    affit_queue #(
        .W     (QD_W),
        .DEPTH (affit_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_q_ready),
        .i_data  (w_q_in),
        .o_valid (w_q_valid),
        .i_ready (w_b_ready),
        .o_data  (w_q_out)
    );

    // Back end: divider and result register
    affit_back #(
        .DIM_BITS  (DIM_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_b_ready),
        .i_ctl      (w_b_ctl),
        .i_num      (w_b_num),
        .i_den      (w_b_den),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_scale_x  (o_scale_x),
        .o_scale_y  (o_scale_y),
        .o_offset_x (o_offset_x),
        .o_offset_y (o_offset_y),
        .o_outcome  (o_outcome)
    );

    // A blocked front end must refuse new requests
    `AFFIT_ASSERT_NOW(a_front_stall, i_clk, i_rst_n, w_f_valid && !w_q_ready, !o_in_ready)

    // A saturated result carries an all-ones scale on one axis
    `AFFIT_ASSERT_NOW(a_sat_scale, i_clk, i_rst_n,
        o_out_valid && (o_outcome == affit_pkg::OC_SAT),
        (o_scale_x == '1) || (o_scale_y == '1))

    // Identity results carry zero offsets
    `AFFIT_ASSERT_NOW(a_ident_offset, i_clk, i_rst_n,
        o_out_valid && ((o_outcome == affit_pkg::OC_INVALID) ||
                        (o_outcome == affit_pkg::OC_IDENT)),
        (o_offset_x == '0) && (o_offset_y == '0))

    // A queue entry offered to a stalled divider stays offered
    `AFFIT_ASSERT_NEXT(a_queue_hold, i_clk, i_rst_n, w_q_valid && !w_b_ready, w_q_valid)

endmodule
